// ===== rtl/core/bplm_pkg.sv =====
`default_nettype none
package bplm_pkg;

    // Input command codes.
    localparam logic [2:0] CMD_TICK    = 3'd0;
    localparam logic [2:0] CMD_SET_ONE = 3'd1;
    localparam logic [2:0] CMD_SET_ALL = 3'd2;
    localparam logic [2:0] CMD_ON      = 3'd3;
    localparam logic [2:0] CMD_OFF     = 3'd4;

    // Matrix geometry.
    localparam int ROWS         = 6;
    localparam int ROW_W        = 3;
    localparam int LEDS_PER_ROW = 4;
    localparam int LED_COUNT    = 24;
    localparam int FWD_ROWS     = 3;

    // Work carried from the read stage into the update stage.
    typedef enum logic [2:0] {
        OP_NONE,
        OP_TICK,
        OP_SET_ONE,
        OP_SET_ALL,
        OP_OFF
    } t_op;

    // Scan sequencer controls, at most one pulse per accepted word.
    typedef struct packed {
        logic tick;
        logic on;
        logic off;
    } t_seq_cmd;

endpackage
`default_nettype wire

// ===== rtl/core/bplm_row_mem.sv =====
`default_nettype none
module bplm_row_mem #(
    parameter int WIDTH = 16
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rd_en,
    input  wire logic [bplm_pkg::ROW_W-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]           o_rd_data,
    input  wire logic                       i_wr_en,
    input  wire logic [bplm_pkg::ROW_W-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]           i_wr_data
);

    // One word per matrix row, holding the plane bits of its four LEDs.
    logic [WIDTH-1:0] r_mem [bplm_pkg::ROWS];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

// ===== rtl/core/bplm_seq.sv =====
`default_nettype none
module bplm_seq #(
    parameter int PLANES = 4,
    parameter int PW     = 2
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire bplm_pkg::t_seq_cmd         i_cmd,
    output logic                            o_enabled,
    output logic      [bplm_pkg::ROW_W-1:0] o_row_next,
    output logic      [PW-1:0]              o_plane_next
);

    localparam logic [PLANES:0] SEQ_LEN = (PLANES+1)'((1 << PLANES) - 1);
    localparam logic [bplm_pkg::ROW_W-1:0] LAST_ROW =
        bplm_pkg::ROW_W'(bplm_pkg::ROWS - 1);

    logic                       r_enabled;
    logic [bplm_pkg::ROW_W-1:0] r_row;
    logic [PLANES-1:0]          r_pos;
    logic [bplm_pkg::ROW_W-1:0] n_row;
    logic [PLANES-1:0]          n_pos;
    logic [PLANES:0]            pos_inc;
    logic [PLANES:0]            next_inc;
    logic [PW:0]                tz;
    logic                       found;

    // The row wraps after the last row and then steps the plane sequence.
    always_comb begin
        pos_inc = {1'b0, r_pos} + 1'b1;
        if (r_row == LAST_ROW) begin
            n_row = '0;
            n_pos = (pos_inc >= SEQ_LEN) ? '0 : pos_inc[PLANES-1:0];
        end else begin
            n_row = r_row + 1'b1;
            n_pos = r_pos;
        end
    end

    // Plane shown is PLANES-1 minus the trailing zeros of position+1.
    always_comb begin
        next_inc = {1'b0, n_pos} + 1'b1;
        tz       = '0;
        found    = 1'b0;
        for (int b = 0; b < PLANES; b++) begin
            if (!found) begin
                if (next_inc[b]) begin
                    found = 1'b1;
                end else begin
                    tz = tz + 1'b1;
                end
            end
        end
        if (tz >= (PW+1)'(PLANES)) begin
            o_plane_next = '0;
        end else begin
            o_plane_next = PW'((PW+1)'(PLANES - 1) - tz);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled <= 1'b0;
            r_row     <= '0;
            r_pos     <= '0;
        end else begin
            if (i_cmd.on) begin
                r_enabled <= 1'b1;
            end else if (i_cmd.off) begin
                r_enabled <= 1'b0;
            end
            if (i_cmd.tick) begin
                r_row <= n_row;
                r_pos <= n_pos;
            end
        end
    end

    assign o_enabled  = r_enabled;
    assign o_row_next = n_row;

endmodule
`default_nettype wire

// ===== rtl/core/bitplane_led_multiplex_scanner.sv =====
`default_nettype none
// Channel   Direction  Handshake                      Words
// s_axis    in         i_s_tvalid / o_s_tready        command, led_index, brightness
// m_axis    out        o_m_tvalid / i_m_tready        latch_byte, direction_byte
// cfg       in         i_cfg_valid / o_cfg_ready      register index, write data
//
// A new word is taken every cycle unless the input stalls: a row read is issued
// when the word is accepted and the modified row is written back in the
// following cycle, so the row memory port pair sets the rate of one word per
// cycle. A result goes through the update stage registers into the output register.
// Reset is synchronous and active low; it needs no clearing pass because every
// row starts marked as holding the shared set-all value.
// The input stalls only while a result waits in the output register and the
// next word in the update stage would produce another one.
module bitplane_led_multiplex_scanner #(
    parameter int PLANES = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Input words.
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [15:0] i_s_tdata,   // command[2:0], led_index[7:3], brightness[15:8]
    // Result words.
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic      [15:0] o_m_tdata,   // latch_byte[7:0], direction_byte[15:8]
    // Configuration writes.
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic        i_cfg_data
);

    localparam int PW = (PLANES > 1) ? $clog2(PLANES) : 1;
    localparam int WW = bplm_pkg::LEDS_PER_ROW * PLANES;
    localparam logic [bplm_pkg::ROW_W-1:0] FWD_ROWS_C = bplm_pkg::ROW_W'(bplm_pkg::FWD_ROWS);
    localparam logic [4:0] LED_COUNT_C = 5'(bplm_pkg::LED_COUNT);
    localparam logic CFG_PIN7_LATCH = 1'b0;
    localparam logic CFG_PIN7_DIR   = 1'b1;

    // Configuration registers; the port never stalls.
    logic r_pin7_lat;
    logic r_pin7_dir;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pin7_lat <= 1'b0;
            r_pin7_dir <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_PIN7_LATCH: r_pin7_lat <= i_cfg_data;
                CFG_PIN7_DIR:   r_pin7_dir <= i_cfg_data;
                default:        r_pin7_lat <= r_pin7_lat;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Accept stage: decode the word, step the scan sequencer and issue
    // the row read.
    // ---------------------------------------------------------------
    logic [2:0]                 a_cmd;
    logic [4:0]                 a_idx;
    logic [7:0]                 a_bright;
    logic                       accept;
    bplm_pkg::t_op              a_op;
    bplm_pkg::t_seq_cmd         seq_cmd;
    logic                       seq_enabled;
    logic [bplm_pkg::ROW_W-1:0] seq_row_next;
    logic [PW-1:0]              seq_plane_next;
    logic [bplm_pkg::ROW_W-1:0] a_row;
    logic                       b_stall;

    assign a_cmd    = i_s_tdata[2:0];
    assign a_idx    = i_s_tdata[7:3];
    assign a_bright = i_s_tdata[15:8];
    assign accept   = i_s_tvalid && o_s_tready;
    assign o_s_tready = !b_stall;

    always_comb begin
        a_op        = bplm_pkg::OP_NONE;
        seq_cmd     = '0;
        unique case (a_cmd)
            bplm_pkg::CMD_TICK: begin
                // Ticks while scanning is off are dropped.
                if (seq_enabled) begin
                    a_op         = bplm_pkg::OP_TICK;
                    seq_cmd.tick = accept;
                end
            end
            bplm_pkg::CMD_SET_ONE: begin
                if (a_idx < LED_COUNT_C) begin
                    a_op = bplm_pkg::OP_SET_ONE;
                end
            end
            bplm_pkg::CMD_SET_ALL: begin
                a_op = bplm_pkg::OP_SET_ALL;
            end
            bplm_pkg::CMD_ON: begin
                seq_cmd.on = accept;
            end
            bplm_pkg::CMD_OFF: begin
                a_op        = bplm_pkg::OP_OFF;
                seq_cmd.off = accept;
            end
            default: begin
                a_op = bplm_pkg::OP_NONE;
            end
        endcase
        a_row = (a_op == bplm_pkg::OP_TICK) ? seq_row_next : a_idx[4:2];
    end

    bplm_seq #(
        .PLANES (PLANES),
        .PW     (PW)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (seq_cmd),
        .o_enabled    (seq_enabled),
        .o_row_next   (seq_row_next),
        .o_plane_next (seq_plane_next)
    );

    // ---------------------------------------------------------------
    // Update stage registers.
    // ---------------------------------------------------------------
    bplm_pkg::t_op              r_b_op;
    logic [bplm_pkg::ROW_W-1:0] r_b_row;
    logic [1:0]                 r_b_slot;
    logic [PLANES-1:0]          r_b_bits;
    logic [PW-1:0]              r_b_plane;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_op <= bplm_pkg::OP_NONE;
        end else if (!b_stall) begin
            r_b_op <= accept ? a_op : bplm_pkg::OP_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!b_stall) begin
            r_b_row   <= a_row;
            r_b_slot  <= a_idx[1:0];
            r_b_bits  <= a_bright[7 -: PLANES];
            r_b_plane <= seq_plane_next;
        end
    end

    // ---------------------------------------------------------------
    // Row memory with set-all overlay and write-back forwarding.
    // A set-all only marks every row stale and keeps the value once; a
    // stale row reads as that value until a single-LED write refreshes it.
    // ---------------------------------------------------------------
    logic [WW-1:0]              mem_q;
    logic                       wr_en;
    logic [WW-1:0]              new_word;
    logic [bplm_pkg::ROWS-1:0]  r_stale;
    logic [PLANES-1:0]          r_glob;
    logic                       r_fwd_valid;
    logic [bplm_pkg::ROW_W-1:0] r_fwd_addr;
    logic [WW-1:0]              r_fwd_data;

    bplm_row_mem #(
        .WIDTH (WW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rd_en   (accept),
        .i_rd_addr (a_row),
        .o_rd_data (mem_q),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_b_row),
        .i_wr_data (new_word)
    );

    logic                              b_back;
    logic [PLANES-1:0]                 b_glob_bits;
    logic [PLANES-1:0]                 b_set_bits;
    logic [WW-1:0]                     b_word;
    logic [bplm_pkg::LEDS_PER_ROW-1:0] b_cols;
    logic [bplm_pkg::ROW_W-1:0]        b_row_mod;
    logic                              b_res;
    logic [7:0]                        b_latch;
    logic [7:0]                        b_dir;

    always_comb begin
        // Rows 3 to 5 hold the backward LEDs, stored inverted.
        b_back      = (r_b_row >= FWD_ROWS_C);
        b_glob_bits = b_back ? ~r_glob : r_glob;
        b_set_bits  = b_back ? ~r_b_bits : r_b_bits;
        if (r_stale[r_b_row]) begin
            b_word = {bplm_pkg::LEDS_PER_ROW{b_glob_bits}};
        end else if (r_fwd_valid && (r_fwd_addr == r_b_row)) begin
            b_word = r_fwd_data;
        end else begin
            b_word = mem_q;
        end

        new_word = b_word;
        for (int s = 0; s < bplm_pkg::LEDS_PER_ROW; s++) begin
            if (r_b_slot == 2'(s)) begin
                new_word[s*PLANES +: PLANES] = b_set_bits;
            end
        end

        for (int c = 0; c < bplm_pkg::LEDS_PER_ROW; c++) begin
            b_cols[c] = b_word[c*PLANES + int'(r_b_plane)];
        end

        b_row_mod = b_back ? (r_b_row - FWD_ROWS_C) : r_b_row;

        if (r_b_op == bplm_pkg::OP_TICK) begin
            b_latch = {r_pin7_lat, b_cols, {3{b_back}}};
            b_dir   = {r_pin7_dir, 4'b0000, ~(3'b001 << b_row_mod[1:0])};
        end else begin
            // Turn-off: every pin but pin 7 drives low; pin 7 keeps its configured values.
            b_latch = {r_pin7_lat, 7'b0000000};
            b_dir   = {r_pin7_dir, 7'b0000000};
        end

        b_res   = (r_b_op == bplm_pkg::OP_TICK) || (r_b_op == bplm_pkg::OP_OFF);
        wr_en   = (r_b_op == bplm_pkg::OP_SET_ONE);
        b_stall = b_res && o_m_tvalid && !i_m_tready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stale     <= '1;
            r_glob      <= '0;
            r_fwd_valid <= 1'b0;
        end else begin
            if (r_b_op == bplm_pkg::OP_SET_ALL) begin
                r_stale     <= '1;
                r_glob      <= r_b_bits;
                r_fwd_valid <= 1'b0;
            end else if (wr_en) begin
                r_stale[r_b_row] <= 1'b0;
                r_fwd_valid      <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_fwd_addr <= r_b_row;
            r_fwd_data <= new_word;
        end
    end

    // ---------------------------------------------------------------
    // Output register.
    // ---------------------------------------------------------------
    logic        r_out_valid;
    logic [15:0] r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (b_res && !b_stall) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_res && !b_stall) begin
            r_out_data <= {b_dir, b_latch};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PLANES       = 4;
    localparam int SEQ_LEN      = (1 << PLANES) - 1;
    localparam int FORWARD_LEDS = bplm_pkg::FWD_ROWS * bplm_pkg::LEDS_PER_ROW;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 10;
    localparam int RUN_LIMIT_NS = 1_000_000;

    // Register indexes of the configuration channel.
    localparam logic REG_PIN7_LEVEL = 1'b0;
    localparam logic REG_PIN7_DIR   = 1'b1;

    // Command codes that the block has no use for.
    localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
    localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;

    // One port write as the block should emit it.
    typedef struct packed {
        logic [7:0] direction_byte;
        logic [7:0] latch_byte;
    } t_port_word;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_s_tvalid  = 1'b0;
    logic        o_s_tready;
    logic [15:0] i_s_tdata   = '0;   // command[2:0], led_index[7:3], brightness[15:8]
    logic        o_m_tvalid;
    logic        i_m_tready  = 1'b0;
    logic [15:0] o_m_tdata;          // latch_byte[7:0], direction_byte[15:8]
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index = 1'b0;
    logic        i_cfg_data  = 1'b0;

    bitplane_led_multiplex_scanner #(
        .PLANES(PLANES)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Our own copy of the scanner: the plane bits per LED, the scan position
    // and the two pin 7 registers.
    logic [PLANES-1:0]          led_planes [bplm_pkg::LED_COUNT];
    logic [bplm_pkg::ROW_W-1:0] scan_row;
    logic [PLANES-1:0]          seq_pos;
    logic                       scan_on;
    logic                       pin7_level;
    logic                       pin7_dir;

    // Port writes that the block still owes us, oldest first.
    t_port_word  port_writes_due[$];
    // Input words waiting for the driver.
    logic [15:0] words_to_send[$];

    int mismatch_count = 0;
    logic s_fire = 1'b0;

    // Knobs the stimulus process turns per phase.
    bit sender_idling   = 1'b1;
    bit receiver_idling = 1'b1;
    bit hold_request    = 1'b0;
    bit hold_served     = 1'b0;
    int hold_cycles_left = 0;
    int send_gap  = 0;
    int stall_left = 0;

    function automatic void reset_model();
        for (int led = 0; led < bplm_pkg::LED_COUNT; led++) begin
            led_planes[led] = (led < FORWARD_LEDS) ? '0 : '1;
        end
        scan_row   = '0;
        seq_pos    = '0;
        scan_on    = 1'b0;
        pin7_level = 1'b0;
        pin7_dir   = 1'b0;
    endfunction

    // Only the top PLANES bits of the brightness survive. Backward LEDs are lit
    // by a low column, so their bits are kept inverted.
    function automatic void store_led(input int led, input logic [7:0] level);
        logic [PLANES-1:0] bits;
        bits = level[7 -: PLANES];
        if (led >= bplm_pkg::LED_COUNT) return;
        if (led >= FORWARD_LEDS) bits = ~bits;
        led_planes[led] = bits;
    endfunction

    // Plane p shows up 2^p times per sequence: the plane at a position is
    // PLANES-1 less the trailing zeros of position+1, never below plane 0.
    function automatic int shown_plane(input logic [PLANES-1:0] pos);
        logic [PLANES:0] v;
        int zeros;
        v = pos + 1'b1;
        zeros = 0;
        while (zeros < PLANES && v[0] == 1'b0) begin
            v = v >> 1;
            zeros++;
        end
        return (zeros >= PLANES) ? 0 : PLANES - 1 - zeros;
    endfunction

    // Applies one accepted word to the model and records the port write it
    // causes, if any.
    function automatic void apply_command(input logic [15:0] word);
        logic [2:0] cmd;
        logic [4:0] idx;
        logic [7:0] level;
        logic [bplm_pkg::LEDS_PER_ROW-1:0] cols;
        int plane;
        int c;
        t_port_word due;
        cmd   = word[2:0];
        idx   = word[7:3];
        level = word[15:8];
        case (cmd)
            bplm_pkg::CMD_TICK: begin
                // A tick while scanning is off leaves everything untouched.
                if (scan_on) begin
                    if (scan_row == bplm_pkg::ROWS - 1) begin
                        scan_row = '0;
                        seq_pos  = (seq_pos == SEQ_LEN - 1) ? '0 : seq_pos + 1'b1;
                    end else begin
                        scan_row = scan_row + 1'b1;
                    end
                    plane = shown_plane(seq_pos);
                    for (c = 0; c < bplm_pkg::LEDS_PER_ROW; c++) begin
                        cols[c] = led_planes[scan_row * bplm_pkg::LEDS_PER_ROW + c][plane];
                    end
                    due.latch_byte = {pin7_level, cols,
                                      (scan_row >= bplm_pkg::FWD_ROWS) ? 3'b111 : 3'b000};
                    due.direction_byte = {pin7_dir, 4'b0000,
                                          ~(3'b001 << (scan_row % bplm_pkg::FWD_ROWS))};
                    port_writes_due.push_back(due);
                end
            end
            bplm_pkg::CMD_SET_ONE: store_led(int'(idx), level);
            bplm_pkg::CMD_SET_ALL: begin
                for (c = 0; c < bplm_pkg::LED_COUNT; c++) store_led(c, level);
            end
            bplm_pkg::CMD_ON: scan_on = 1'b1;
            bplm_pkg::CMD_OFF: begin
                // Turning off always parks pins 0 to 6 low, whatever the state.
                scan_on = 1'b0;
                due.latch_byte     = {pin7_level, 7'b0};
                due.direction_byte = {pin7_dir, 7'b0};
                port_writes_due.push_back(due);
            end
            default: ;
        endcase
    endfunction

    // Gap lengths: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void push_word(input logic [2:0] cmd, input logic [4:0] idx,
                                      input logic [7:0] level);
        words_to_send.push_back({level, idx, cmd});
    endfunction

    // Edge values and every special case: ticks while off, set commands on
    // both halves of the matrix, indexes past the last LED, spare codes, and the
    // on/off pair with results on both forward and backward rows.
    function automatic void queue_directed_words();
        push_word(bplm_pkg::CMD_TICK,    5'd31, 8'hFF);
        push_word(bplm_pkg::CMD_SET_ONE, 5'd0,  8'hF0);
        push_word(bplm_pkg::CMD_SET_ONE, 5'd11, 8'h10);
        push_word(bplm_pkg::CMD_SET_ONE, 5'd12, 8'hFF);
        push_word(bplm_pkg::CMD_SET_ONE, 5'd23, 8'h00);
        push_word(bplm_pkg::CMD_SET_ONE, 5'd24, 8'hAA);
        push_word(bplm_pkg::CMD_SET_ONE, 5'd31, 8'h55);
        push_word(CMD_SPARE_FIRST, 5'd5, 8'h0F);
        push_word(CMD_SPARE_LAST,  5'd0, 8'hFF);
        push_word(bplm_pkg::CMD_ON,      5'd0,  8'h00);
        for (int k = 0; k < 8; k++) push_word(bplm_pkg::CMD_TICK, 5'(k), 8'(k * 33));
        push_word(bplm_pkg::CMD_SET_ALL, 5'd31, 8'h90);
        for (int k = 0; k < 3; k++) push_word(bplm_pkg::CMD_TICK, 5'd0, 8'h00);
        push_word(bplm_pkg::CMD_OFF,     5'd0,  8'h00);
        push_word(bplm_pkg::CMD_TICK,    5'd0,  8'h00);
        push_word(bplm_pkg::CMD_ON,      5'd31, 8'hFF);
        push_word(bplm_pkg::CMD_OFF,     5'd31, 8'hFF);
    endfunction

    // Mostly a running scan with LED updates mixed in; the rest is off/on
    // toggles, out-of-range indexes and spare codes. Field bits not used by a
    // command are still random so every input bit moves.
    function automatic void queue_random_words(input int count);
        int sent;
        int pick;
        logic [2:0] cmd;
        logic [4:0] idx;
        logic [7:0] level;
        sent = 0;
        push_word(bplm_pkg::CMD_ON, 5'($urandom_range(0, 31)), 8'($urandom));
        while (sent < count) begin
            pick  = $urandom_range(0, 99);
            idx   = 5'($urandom_range(0, 31));
            level = 8'($urandom);
            if (pick < 58) begin
                cmd = bplm_pkg::CMD_TICK;
            end else if (pick < 76) begin
                cmd = bplm_pkg::CMD_SET_ONE;
                idx = 5'($urandom_range(0, bplm_pkg::LED_COUNT - 1));
            end else if (pick < 81) begin
                cmd = bplm_pkg::CMD_SET_ALL;
            end else if (pick < 86) begin
                push_word(bplm_pkg::CMD_OFF, idx, level);
                sent++;
                cmd = bplm_pkg::CMD_ON;
            end else if (pick < 91) begin
                cmd = bplm_pkg::CMD_SET_ONE;
                idx = 5'($urandom_range(bplm_pkg::LED_COUNT, 31));
            end else if (pick < 95) begin
                cmd = 3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
            end else if (pick < 97) begin
                cmd = bplm_pkg::CMD_OFF;
            end else begin
                cmd = bplm_pkg::CMD_ON;
            end
            push_word(cmd, idx, level);
            sent++;
        end
    endfunction

    task automatic write_port_reg(input logic index, input logic value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_port_regs(input logic level, input logic dir);
        write_port_reg(REG_PIN7_LEVEL, level);
        write_port_reg(REG_PIN7_DIR, dir);
    endtask

    // The block is idle once every word is in and every port write is out.
    // Words without a result may still be in the pipe, so let them drain before
    // touching the registers.
    task automatic wait_until_drained();
        while (words_to_send.size() != 0 || i_s_tvalid || port_writes_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Sender: a new word goes out once the last one was taken and its gap ran
    // out. Inputs only change on the falling edge.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (!i_s_tvalid || s_fire) begin
            if (send_gap > 0) begin
                i_s_tvalid <= 1'b0;
                send_gap   <= send_gap - 1;
            end else if (words_to_send.size() != 0) begin
                i_s_tdata  <= words_to_send.pop_front();
                i_s_tvalid <= 1'b1;
                send_gap   <= sender_idling ? pick_gap() : 0;
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off so that the output
    // register fills and the block has to push back on its input.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (hold_cycles_left > 0) begin
            i_m_tready       <= 1'b0;
            hold_cycles_left <= hold_cycles_left - 1;
        end else if (hold_request && !hold_served) begin
            i_m_tready       <= 1'b0;
            hold_cycles_left <= HOLD_CYCLES;
            hold_served      <= 1'b1;
        end else if (stall_left > 0) begin
            i_m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            i_m_tready <= 1'b1;
            if (receiver_idling && $urandom_range(0, 99) < 30) stall_left <= pick_gap();
        end
    end

    // Monitor: everything is sampled on the rising edge. Results are checked
    // before the word taken on the same edge is applied to the model.
    always @(posedge i_clk) begin : monitor
        t_port_word due;
        if (!i_rst_n) begin
            s_fire <= 1'b0;
        end else begin
            s_fire <= i_s_tvalid && o_s_tready;
            if (o_m_tvalid && i_m_tready) begin
                if (port_writes_due.size() == 0) begin
                    $error("result word %h arrived with nothing expected", o_m_tdata);
                    mismatch_count++;
                end else begin
                    due = port_writes_due.pop_front();
                    if (o_m_tdata[7:0] !== due.latch_byte) begin
                        $error("latch_byte expected %h actual %h",
                               due.latch_byte, o_m_tdata[7:0]);
                        mismatch_count++;
                    end
                    if (o_m_tdata[15:8] !== due.direction_byte) begin
                        $error("direction_byte expected %h actual %h",
                               due.direction_byte, o_m_tdata[15:8]);
                        mismatch_count++;
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_PIN7_LEVEL: pin7_level = i_cfg_data;
                    REG_PIN7_DIR:   pin7_dir   = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_s_tvalid && o_s_tready) apply_command(i_s_tdata);
        end
    end

    // Stimulus in phases, each with its own pin 7 setting. The second phase
    // runs without any idling on either side; the third carries the long
    // receiver hold-off.
    initial begin
        reset_model();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        set_port_regs(1'b0, 1'b0);
        queue_directed_words();
        wait_until_drained();

        sender_idling   = 1'b0;
        receiver_idling = 1'b0;
        set_port_regs(1'b1, 1'b1);
        queue_random_words(330);
        wait_until_drained();

        sender_idling   = 1'b1;
        receiver_idling = 1'b1;
        set_port_regs(1'b1, 1'b0);
        queue_random_words(330);
        hold_request = 1'b1;
        wait_until_drained();

        set_port_regs(1'b0, 1'b1);
        queue_random_words(330);
        wait_until_drained();

        set_port_regs(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        queue_random_words(335);
        wait_until_drained();

        if (mismatch_count == 0) begin
            $display("PASS bitplane_led_multiplex_scanner");
        end else begin
            $display("FAIL bitplane_led_multiplex_scanner");
        end
        $finish;
    end

    // A hung handshake or a port write that never shows up ends up here.
    initial begin
        #(RUN_LIMIT_NS);
        $display("FAIL bitplane_led_multiplex_scanner");
        $finish;
    end

endmodule
